@@ rtl/eml_pkg.sv @@
// ----------------------------------------------------------------------------
// eml_pkg
// Types and constants shared by front and back, and the back's trim function.
// ----------------------------------------------------------------------------
`default_nettype none

package eml_pkg;

   localparam int OFF_W  = 50;
   localparam int LEN_W  = 14;
   localparam int MOFF_W = 55;
   localparam int TAG_W  = 8;
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int LIM_W  = 7;
   localparam int END_W  = OFF_W + 1;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic [OFF_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
      logic [MOFF_W-1:0] moffset;
      logic              zeroed;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic              is_write;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_idx;
      entry_type         entry;
      logic [OFF_W-1:0]  qoff;
      logic [END_W-1:0]  qend;
      logic              qempty;
      logic [LIM_W-1:0]  lim;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SCMP,
      ST_SCAN,
      ST_XCMP,
      ST_FINISH
   } state_type;

   function automatic entry_type trim(entry_type e, logic [OFF_W-1:0] qoff,
                                      logic [END_W-1:0] qend);
      entry_type        r;
      logic [OFF_W-1:0] d;
      logic [END_W-1:0] e_end;
      r = e;
      d = '0;
      if (e.offset < qoff) begin
         d = qoff - e.offset;
         r.offset = qoff;
         if (d >= {{(OFF_W-LEN_W){1'b0}}, e.length}) begin
            r.length = '0;
         end else begin
            r.length = e.length - d[LEN_W-1:0];
         end
         if (!e.zeroed) begin
            r.moffset = e.moffset + {{(MOFF_W-OFF_W){1'b0}}, d};
         end
      end
      e_end = {1'b0, r.offset} + {{(END_W-LEN_W){1'b0}}, r.length};
      if (e_end > qend) begin
         if (qend > {1'b0, r.offset}) begin
            r.length = LEN_W'(qend - {1'b0, r.offset});
         end else begin
            r.length = '0;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/eml_front.sv @@
// ----------------------------------------------------------------------------
// eml_front
// Accepts request items, classifies them and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
`default_nettype none

module eml_front #(
   parameter int TABLE_DEPTH = 1024,
   parameter int MAX_RESULTS = 16
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire                            req_operation,
   input  wire  [eml_pkg::IDX_W-1:0]      req_entry_index,
   input  wire  [eml_pkg::OFF_W-1:0]      req_entry_offset,
   input  wire  [eml_pkg::LEN_W-1:0]      req_entry_length,
   input  wire  [eml_pkg::MOFF_W-1:0]     req_entry_moffset,
   input  wire                            req_entry_zeroed,
   input  wire  [eml_pkg::TAG_W-1:0]      req_entry_tag,
   input  wire  [eml_pkg::OFF_W-1:0]      req_query_offset,
   input  wire  [eml_pkg::LEN_W-1:0]      req_query_length,
   input  wire  [4:0]                     req_result_limit,
   output logic                           cmd_valid,
   output eml_pkg::cmd_type               cmd,
   input  wire                            cmd_pop
);

   eml_pkg::cmd_type q_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       num_ff, num_in;
   eml_pkg::cmd_type c;
   logic [4:0]       lim1;
   logic             push;

   always_comb begin
      lim1 = (req_result_limit == 5'd0) ? 5'd1 : req_result_limit;
      c.is_write = (req_operation == eml_pkg::OP_WRITE);
      c.wr_en    = (32'(req_entry_index) < TABLE_DEPTH);
      c.wr_idx   = req_entry_index;
      c.entry.offset  = req_entry_offset;
      c.entry.length  = req_entry_length;
      c.entry.moffset = req_entry_moffset;
      c.entry.zeroed  = req_entry_zeroed;
      c.entry.tag     = req_entry_tag;
      c.qoff   = req_query_offset;
      c.qend   = {1'b0, req_query_offset} +
                 {{(eml_pkg::END_W-eml_pkg::LEN_W){1'b0}}, req_query_length};
      c.qempty = (req_query_length == '0);
      c.lim    = (32'(lim1) > MAX_RESULTS) ? eml_pkg::LIM_W'(MAX_RESULTS)
                                           : eml_pkg::LIM_W'(lim1);
   end

   assign req_ready = (num_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (num_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = cmd_pop ? ~rp_ff : rp_ff;
      num_in = num_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         num_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         num_ff <= num_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= c;
      end
   end

endmodule

`default_nettype wire

@@ rtl/eml_back.sv @@
// ----------------------------------------------------------------------------
// eml_back
// Executes queued items: table writes, binary search, scan and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module eml_back #(
   parameter int TABLE_DEPTH = 1024,
   parameter int MAX_RESULTS = 16
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            cmd_valid,
   input  eml_pkg::cmd_type               cmd,
   output logic                           cmd_pop,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire  [eml_pkg::CNT_W-1:0]      csr_data,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic                           rsp_found,
   output logic [eml_pkg::OFF_W-1:0]      rsp_out_offset,
   output logic [eml_pkg::LEN_W-1:0]      rsp_out_length,
   output logic [eml_pkg::MOFF_W-1:0]     rsp_out_moffset,
   output logic                           rsp_out_zeroed,
   output logic [eml_pkg::TAG_W-1:0]      rsp_out_tag,
   output logic                           rsp_last
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int LW = $clog2(MAX_RESULTS + 1);

   eml_pkg::entry_type mem [TABLE_DEPTH];
   eml_pkg::entry_type rd_ff;

   eml_pkg::state_type state_ff, state_in;
   logic [eml_pkg::CNT_W-1:0] csr_ff;
   logic [CW-1:0]  count;
   logic [CW-1:0]  lo_ff, lo_in, hip1_ff, hip1_in, pos_ff, pos_in;
   logic [LW-1:0]  cnt_ff, cnt_in;
   eml_pkg::entry_type pend_ff, pend_in;
   logic           pvld_ff, pvld_in, pfirst_ff, pfirst_in;
   logic [eml_pkg::OFF_W-1:0] qoff_ff, qoff_in;
   logic [eml_pkg::END_W-1:0] qend_ff, qend_in;
   logic [eml_pkg::LIM_W-1:0] lim_ff, lim_in;
   logic [CW:0]    msum;
   logic [AW-1:0]  mid, raddr;
   logic           we;
   logic [AW-1:0]  waddr;
   logic           out_free, emit, emit_found, emit_last;
   eml_pkg::entry_type emit_e;
   logic           hit, stop, more;
   logic           rvalid_ff;
   logic           rfound_ff, rlast_ff;
   eml_pkg::entry_type rent_ff;

   assign csr_ready = 1'b1;
   assign count     = (32'(csr_ff) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(csr_ff);
   assign msum      = {1'b0, lo_ff} + {1'b0, hip1_ff} - {{CW{1'b0}}, 1'b1};
   assign mid       = msum[AW:1];
   assign out_free  = !rvalid_ff || rsp_ready;
   assign hit  = ({1'b0, qoff_ff} >= ({1'b0, rd_ff.offset} +
                 {{(eml_pkg::END_W-eml_pkg::LEN_W){1'b0}}, rd_ff.length}));
   assign stop = ({1'b0, rd_ff.offset} >= qend_ff);
   assign more = (pos_ff < count) && (32'(cnt_ff) < 32'(lim_ff));
   assign waddr = AW'(32'(cmd.wr_idx));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         eml_pkg::ST_IDLE: begin
            if (cmd_valid && !cmd.is_write) begin
               state_in = cmd.qempty ? eml_pkg::ST_FINISH : eml_pkg::ST_SEARCH;
            end
         end
         eml_pkg::ST_SEARCH:
            state_in = (lo_ff < hip1_ff) ? eml_pkg::ST_SCMP : eml_pkg::ST_SCAN;
         eml_pkg::ST_SCMP:
            state_in = eml_pkg::ST_SEARCH;
         eml_pkg::ST_SCAN:
            state_in = more ? eml_pkg::ST_XCMP : eml_pkg::ST_FINISH;
         eml_pkg::ST_XCMP: begin
            if (stop) begin
               state_in = eml_pkg::ST_FINISH;
            end else if (!pvld_ff || out_free) begin
               state_in = eml_pkg::ST_SCAN;
            end
         end
         eml_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = eml_pkg::ST_IDLE;
            end
         end
         default: state_in = eml_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop    = 1'b0;
      we         = 1'b0;
      raddr      = pos_ff[AW-1:0];
      lo_in      = lo_ff;
      hip1_in    = hip1_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      pend_in    = pend_ff;
      pvld_in    = pvld_ff;
      pfirst_in  = pfirst_ff;
      qoff_in    = qoff_ff;
      qend_in    = qend_ff;
      lim_in     = lim_ff;
      emit       = 1'b0;
      emit_found = 1'b1;
      emit_last  = 1'b0;
      emit_e     = pend_ff;
      case (state_ff)
         eml_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               we      = cmd.is_write && cmd.wr_en;
               qoff_in = cmd.qoff;
               qend_in = cmd.qend;
               lim_in  = cmd.lim;
               lo_in   = '0;
               hip1_in = count;
               cnt_in  = '0;
               pvld_in = 1'b0;
            end
         end
         eml_pkg::ST_SEARCH: begin
            raddr = mid;
            if (lo_ff < hip1_ff) begin
               pos_in = {{(CW-AW){1'b0}}, mid};
            end else begin
               pos_in = lo_ff;
            end
         end
         eml_pkg::ST_SCMP: begin
            if (hit) begin
               lo_in = pos_ff + {{(CW-1){1'b0}}, 1'b1};
            end else begin
               hip1_in = pos_ff;
            end
         end
         eml_pkg::ST_SCAN: begin
            if (lo_ff != pos_ff && cnt_ff == '0 && !pvld_ff) begin
               pos_in = lo_ff;
            end
            raddr = (cnt_ff == '0 && !pvld_ff) ? lo_ff[AW-1:0] : pos_ff[AW-1:0];
         end
         eml_pkg::ST_XCMP: begin
            if (!stop && (!pvld_ff || out_free)) begin
               emit      = pvld_ff;
               emit_e    = pfirst_ff ? eml_pkg::trim(pend_ff, qoff_ff, qend_ff)
                                     : pend_ff;
               pend_in   = rd_ff;
               pvld_in   = 1'b1;
               pfirst_in = (cnt_ff == '0);
               cnt_in    = cnt_ff + {{(LW-1){1'b0}}, 1'b1};
               pos_in    = pos_ff + {{(CW-1){1'b0}}, 1'b1};
            end
         end
         eml_pkg::ST_FINISH: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_last  = 1'b1;
               emit_found = pvld_ff;
               emit_e     = pvld_ff ? eml_pkg::trim(pend_ff, qoff_ff, qend_ff) : '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= eml_pkg::ST_IDLE;
         csr_ff    <= '0;
         rvalid_ff <= 1'b0;
         pvld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pvld_ff  <= pvld_in;
         if (csr_valid && csr_ready) begin
            csr_ff <= csr_data;
         end
         if (emit) begin
            rvalid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hip1_ff   <= hip1_in;
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
      pend_ff   <= pend_in;
      pfirst_ff <= pfirst_in;
      qoff_ff   <= qoff_in;
      qend_ff   <= qend_in;
      lim_ff    <= lim_in;
      if (emit) begin
         rent_ff   <= emit_e;
         rfound_ff <= emit_found;
         rlast_ff  <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= cmd.entry;
      end
      rd_ff <= mem[raddr];
   end

   assign rsp_valid       = rvalid_ff;
   assign rsp_found       = rfound_ff;
   assign rsp_out_offset  = rent_ff.offset;
   assign rsp_out_length  = rent_ff.length;
   assign rsp_out_moffset = rent_ff.moffset;
   assign rsp_out_zeroed  = rent_ff.zeroed;
   assign rsp_out_tag     = rent_ff.tag;
   assign rsp_last        = rlast_ff;

endmodule

`default_nettype wire

@@ rtl/extent_map_range_lookup.sv @@
// ----------------------------------------------------------------------------
// extent_map_range_lookup
// Sorted extent table with binary search and trimmed range results.
// ----------------------------------------------------------------------------
//  port group  dir  role
//  req_*       in   write or lookup item
//  rsp_*       out  result item, one or more per lookup
//  csr_*       in   entry_count register write
//
// a write is done in the back end's idle state; a lookup steps through the
// search and compare states for the binary search, then the scan and compare states per result,
// both set by the single registered-read table port.
// a two-deep queue sits between front and back, the result register
// decouples the back end from rsp_ready.
// reset clears control state and entry_count; table contents stay undefined.
`default_nettype none

module extent_map_range_lookup #(
   parameter int TABLE_DEPTH = 1024,
   parameter int MAX_RESULTS = 16
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire                            req_operation,
   input  wire  [eml_pkg::IDX_W-1:0]      req_entry_index,
   input  wire  [eml_pkg::OFF_W-1:0]      req_entry_offset,
   input  wire  [eml_pkg::LEN_W-1:0]      req_entry_length,
   input  wire  [eml_pkg::MOFF_W-1:0]     req_entry_moffset,
   input  wire                            req_entry_zeroed,
   input  wire  [eml_pkg::TAG_W-1:0]      req_entry_tag,
   input  wire  [eml_pkg::OFF_W-1:0]      req_query_offset,
   input  wire  [eml_pkg::LEN_W-1:0]      req_query_length,
   input  wire  [4:0]                     req_result_limit,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire  [eml_pkg::CNT_W-1:0]      csr_data,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic                           rsp_found,
   output logic [eml_pkg::OFF_W-1:0]      rsp_out_offset,
   output logic [eml_pkg::LEN_W-1:0]      rsp_out_length,
   output logic [eml_pkg::MOFF_W-1:0]     rsp_out_moffset,
   output logic                           rsp_out_zeroed,
   output logic [eml_pkg::TAG_W-1:0]      rsp_out_tag,
   output logic                           rsp_last
);

   logic             cmd_valid, cmd_pop;
   eml_pkg::cmd_type cmd;

   eml_front #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_RESULTS(MAX_RESULTS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_operation, .req_entry_index,
      .req_entry_offset, .req_entry_length, .req_entry_moffset, .req_entry_zeroed,
      .req_entry_tag, .req_query_offset, .req_query_length, .req_result_limit,
      .cmd_valid, .cmd, .cmd_pop
   );

   eml_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_RESULTS(MAX_RESULTS)) u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_pop, .csr_valid, .csr_ready, .csr_data,
      .rsp_valid, .rsp_ready, .rsp_found, .rsp_out_offset, .rsp_out_length,
      .rsp_out_moffset, .rsp_out_zeroed, .rsp_out_tag, .rsp_last
   );

endmodule

`default_nettype wire
